### hdl/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants of the polyphase row resampler
// Holds the table sizes, the register and request codes, the controller states
// and the per-tap control word that is passed to the MAC.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int MAX_HALF_TAPS = 8;
  localparam int MAX_PHASES    = 64;
  localparam int MAX_WIDTH     = 4096;
  localparam int TAPS_MAX      = 2 * MAX_HALF_TAPS + 1;
  localparam int COEF_DEPTH    = MAX_PHASES * TAPS_MAX;
  localparam int COEF_AW       = $clog2(COEF_DEPTH);
  localparam int BURST_MAX     = 64;
  localparam int CNT_MAX       = 8191;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef enum logic [2:0] {
    CFG_PHASE_COUNT = 3'd0,
    CFG_STEP_WHOLE  = 3'd1,
    CFG_STEP_FRAC   = 3'd2,
    CFG_OUT_WIDTH   = 3'd3,
    CFG_HALF_TAPS   = 3'd4
  } prr_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } prr_state_e;

  typedef struct packed {
    logic en;
    logic first;
    logic last;
  } prr_tap_t;

endpackage

### hdl/prr_if.sv
// ----------------------------------------------------------------------------
// prr_if: stream interfaces of the polyphase row resampler
// Request channel (samples and coefficient writes) and result channel.
// ----------------------------------------------------------------------------
interface prr_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] sample;
  logic               row_start;
  logic        [5:0]  coef_phase;
  logic        [4:0]  coef_tap;
  logic signed [17:0] coef_value;

  modport source (output valid, req_type, sample, row_start, coef_phase, coef_tap,
                  coef_value, input ready);
  modport sink (input valid, req_type, sample, row_start, coef_phase, coef_tap,
                coef_value, output ready);
endinterface

interface prr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel;
  logic        [11:0] out_position;
  logic               last_of_run;
  logic               end_of_row;

  modport source (output valid, pixel, out_position, last_of_run, end_of_row,
                  input ready);
  modport sink (input valid, pixel, out_position, last_of_run, end_of_row,
                output ready);
endinterface

### hdl/polyphase_row_resampler_core.sv
// ----------------------------------------------------------------------------
// polyphase_row_resampler_core: polyphase FIR row resampler
// A sample with no output due passes from the check state back to idle.
// Each output accumulates 2*half_taps+1 taps read through the coefficient memory
// read port and the MAC in fetch, multiply, accumulate and load steps.
// The next item is taken while the last result still waits on the output.
// Reset (asynchronous, active low) clears control, counters and the window;
// the coefficient table is undefined until written.
// ----------------------------------------------------------------------------
module polyphase_row_resampler_core
  import prr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [12:0]  cfg_data_i,
  prr_in_if.sink       in_i,
  prr_out_if.source    out_o
);

  logic [6:0]  phase_count_q;
  logic [12:0] step_whole_q;
  logic [5:0]  step_frac_q;
  logic [12:0] out_width_q;
  logic [3:0]  half_taps_q;

  prr_state_e  state_q, state_d;
  logic signed [15:0] window_q [TAPS_MAX];
  logic [12:0] seen_q, idx_q, done_cnt_q, center_q;
  logic [5:0]  phase_q;
  logic [6:0]  burst_q;
  logic [4:0]  tap_q;

  logic        accept, issue, emit_go;
  logic [3:0]  n_eff;
  logic [4:0]  two_n;
  logic [6:0]  m_eff;
  logic [12:0] ow_eff;
  logic        due_now, due_next;
  logic [6:0]  sum7;
  logic        carry;
  logic [5:0]  phase_nx;
  logic [14:0] center_sum;
  logic [12:0] center_nx, done_nx, seen_base;
  logic [6:0]  burst_nx;
  logic [4:0]  win_idx;

  prr_tap_t           tap_s1_q;
  logic signed [15:0] samp_s1_q;
  logic signed [17:0] coef_rd;
  logic [COEF_AW-1:0] raddr, waddr;
  logic               mac_done;
  logic signed [15:0] mac_pixel;

  logic               out_valid_q;
  logic signed [15:0] pixel_q;
  logic [11:0]        pos_q;
  logic               last_q, eor_q;

  // effective register values
  always_comb begin
    if (half_taps_q == 4'd0) begin
      n_eff = 4'd1;
    end else if (half_taps_q > 4'(MAX_HALF_TAPS)) begin
      n_eff = 4'(MAX_HALF_TAPS);
    end else begin
      n_eff = half_taps_q;
    end
    two_n  = {n_eff, 1'b0};
    m_eff  = (phase_count_q == 7'd0) ? 7'd1 : phase_count_q;
    ow_eff = (out_width_q > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : out_width_q;
  end

  // advance position after one output
  always_comb begin
    sum7  = {1'b0, phase_q} + {1'b0, step_frac_q};
    carry = (sum7 >= m_eff);
    phase_nx   = carry ? 6'(sum7 - m_eff) : sum7[5:0];
    center_sum = {2'b00, center_q} + {2'b00, step_whole_q} + {14'd0, carry};
    center_nx  = (center_sum > 15'(CNT_MAX)) ? 13'(CNT_MAX) : center_sum[12:0];
    done_nx    = done_cnt_q + 13'd1;
    burst_nx   = burst_q + 7'd1;
    due_now  = (burst_q < 7'(BURST_MAX)) && (done_cnt_q < ow_eff)
            && ({1'b0, center_q} + {9'd0, two_n} <= {1'b0, idx_q});
    due_next = (burst_nx < 7'(BURST_MAX)) && (done_nx < ow_eff)
            && ({1'b0, center_nx} + {9'd0, two_n} <= {1'b0, idx_q});
  end

  // control outputs
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    accept     = in_i.valid && (state_q == ST_IDLE);
    issue      = (state_q == ST_RUN);
    emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_i.req_type == REQ_SAMPLE) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = due_now ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        if (tap_q == two_n) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = due_next ? ST_RUN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_count_q <= 7'd1;
      step_whole_q  <= 13'd1;
      step_frac_q   <= 6'd0;
      out_width_q   <= 13'd1;
      half_taps_q   <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_COUNT: phase_count_q <= cfg_data_i[6:0];
        CFG_STEP_WHOLE:  step_whole_q  <= cfg_data_i;
        CFG_STEP_FRAC:   step_frac_q   <= cfg_data_i[5:0];
        CFG_OUT_WIDTH:   out_width_q   <= cfg_data_i;
        CFG_HALF_TAPS:   half_taps_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign seen_base = in_i.row_start ? 13'd0 : seen_q;

  // control state, counters and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      seen_q     <= '0;
      idx_q      <= '0;
      done_cnt_q <= '0;
      center_q   <= '0;
      phase_q    <= '0;
      burst_q    <= '0;
      tap_q      <= '0;
      tap_s1_q   <= '0;
      for (int i = 0; i < TAPS_MAX; i++) begin
        window_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      tap_s1_q <= '{en: issue, first: (tap_q == 5'd0), last: (tap_q == two_n)};
      if (accept && in_i.req_type == REQ_SAMPLE) begin
        for (int i = TAPS_MAX - 1; i > 0; i--) begin
          window_q[i] <= window_q[i-1];
        end
        window_q[0] <= in_i.sample;
        idx_q       <= seen_base;
        seen_q      <= (seen_base == 13'(CNT_MAX)) ? seen_base : seen_base + 13'd1;
        burst_q     <= '0;
        tap_q       <= '0;
        if (in_i.row_start) begin
          done_cnt_q <= '0;
          center_q   <= '0;
          phase_q    <= '0;
        end
      end
      if (issue) begin
        tap_q <= (tap_q == two_n) ? 5'd0 : tap_q + 5'd1;
      end
      if (emit_go) begin
        done_cnt_q <= done_nx;
        center_q   <= center_nx;
        phase_q    <= phase_nx;
        burst_q    <= burst_nx;
      end
    end
  end

  // tap fetch
  assign win_idx = two_n - tap_q;
  assign raddr   = COEF_AW'({phase_q, 4'd0}) + COEF_AW'(phase_q) + COEF_AW'(tap_q);
  assign waddr   = COEF_AW'({in_i.coef_phase, 4'd0}) + COEF_AW'(in_i.coef_phase)
                 + COEF_AW'(in_i.coef_tap);

  always_ff @(posedge clk_i) begin
    samp_s1_q <= window_q[win_idx];
  end

  prr_coef_mem u_coef_mem (
    .clk_i   (clk_i),
    .we_i    (accept && in_i.req_type == REQ_COEF
              && in_i.coef_tap < 5'(TAPS_MAX)),
    .waddr_i (waddr),
    .wdata_i (in_i.coef_value),
    .raddr_i (raddr),
    .rdata_o (coef_rd)
  );

  prr_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tap_i    (tap_s1_q),
    .sample_i (samp_s1_q),
    .coef_i   (coef_rd),
    .done_o   (mac_done),
    .pixel_o  (mac_pixel)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      pixel_q <= mac_pixel;
      pos_q   <= done_cnt_q[11:0];
      last_q  <= !due_next;
      eor_q   <= (done_nx == ow_eff);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel        = pixel_q;
  assign out_o.out_position = pos_q;
  assign out_o.last_of_run  = last_q;
  assign out_o.end_of_row   = eor_q;

endmodule

### hdl/prr_coef_mem.sv
// ----------------------------------------------------------------------------
// prr_coef_mem: coefficient table
// One write port, one read port with registered read data, phase-major layout.
// ----------------------------------------------------------------------------
module prr_coef_mem
  import prr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [COEF_AW-1:0]       waddr_i,
  input  logic signed [17:0]       wdata_i,
  input  logic [COEF_AW-1:0]       raddr_i,
  output logic signed [17:0]       rdata_o
);

  logic signed [17:0] mem_q [COEF_DEPTH];
  logic signed [17:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/prr_mac.sv
// ----------------------------------------------------------------------------
// prr_mac: tap multiply-accumulate
// Multiplies one sample by one coefficient per cycle, accumulates the taps of
// one output and rounds and saturates the sum to Q1.15.
// ----------------------------------------------------------------------------
module prr_mac
  import prr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prr_tap_t           tap_i,
  input  logic signed [15:0] sample_i,
  input  logic signed [17:0] coef_i,
  output logic               done_o,
  output logic signed [15:0] pixel_o
);

  logic signed [33:0] prod_q;
  prr_tap_t           prod_ctl_q;
  logic signed [37:0] acc_q;
  logic               done_q;
  logic signed [37:0] rnd;
  logic signed [21:0] quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ctl_q <= '0;
      done_q     <= 1'b0;
    end else begin
      prod_ctl_q <= tap_i;
      done_q     <= prod_ctl_q.en && prod_ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * coef_i;
    if (prod_ctl_q.en) begin
      if (prod_ctl_q.first) begin
        acc_q <= 38'(prod_q);
      end else begin
        acc_q <= acc_q + 38'(prod_q);
      end
    end
  end

  always_comb begin
    rnd = acc_q + 38'sd32768;
    quo = 22'(rnd >>> 16);
    if (quo > 22'sd32767) begin
      pixel_o = 16'sh7fff;
    end else if (quo < -22'sd32768) begin
      pixel_o = -16'sh8000;
    end else begin
      pixel_o = 16'(quo);
    end
  end

  assign done_o = done_q;

endmodule
